@@ hdl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: payload structs,
// result kinds, register indexes and the internal request structs.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int RAM_BANKS      = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_BANK_W     = $clog2(RAM_BANKS);
    localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_ADDR_W     = RAM_BANK_W + RAM_OFF_W;

    localparam int ROM_ADDR_W     = 19;
    localparam int ROM_OFF_W      = 14;
    localparam int ROM_BANK_W     = 5;

    localparam int CFG_INDEX_W    = 8;

    localparam logic [7:0] BYTE_FF      = 8'hFF;
    localparam logic [3:0] RAM_EN_KEY   = 4'hA;
    localparam logic [2:0] RAM_SIZE_MAX = 3'h2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROM_BANK_COUNT = 8'd0,
        CFG_RAM_SIZE_CODE  = 8'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_ROM   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    // Control register window below 0x8000, selected by address bits 14:13
    typedef enum logic [1:0] {
        SEL_RAM_EN   = 2'd0,
        SEL_ROM_BANK = 2'd1,
        SEL_RAM_BANK = 2'd2,
        SEL_MODE     = 2'd3
    } t_ctl_sel;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [7:0]            read_data;
    } t_out_item;

    typedef struct packed {
        logic                  re;
        logic                  we;
        logic [RAM_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_req;

    typedef struct packed {
        t_kind                 kind;
        logic [ROM_ADDR_W-1:0] rom_addr;
        logic                  use_ram;
        logic [7:0]            fixed_data;
    } t_issue;

endpackage

@@ hdl/cartridge_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// MBC1-style cartridge bank mapper: decodes CPU bus transfers, keeps the
// banking registers and the cartridge RAM, returns one result per transfer.
// ----------------------------------------------------------------------------
// One bus transfer is taken per clock while o_in_ready is high, and each
// gives exactly one result: the accept cycle decodes the address and issues
// the RAM access, the next cycle holds the registered RAM read data next to
// the decoded result, and the output register presents it. The single-port
// RAM handles one access per transfer, so the sustained rate is one transfer
// per cycle with output ready. Banking registers and RAM writes take effect at
// the accept edge, so a following transfer always sees them without forwarding.
// A middle stage and the output register form a two-deep buffer: input ready
// stays high while a finished result waits, as long as the middle stage is
// free. RAM contents are undefined after reset and need no clearing pass;
// configuration writes are taken every cycle and belong only in idle periods.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // bus transfer in
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    // result out
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    t_mem_req   mem_req;
    t_issue     issue;
    logic [7:0] ram_rdata;

    logic       in_accept;
    logic       mid_move;

    // middle stage: decoded result beside the RAM read data
    logic       r_mid_valid, n_mid_valid;
    t_issue     r_mid;

    // output register
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    t_out_item  mid_item;

    // Advance the middle stage when the output register is free or draining
    assign mid_move   = r_mid_valid && (!r_out_valid || i_out_ready);
    // Take a transfer whenever the middle stage is empty or moves on
    assign o_in_ready = !r_mid_valid || mid_move;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .o_mem       (mem_req),
        .o_issue     (issue)
    );

    // Read data only updates on a new RAM read, so it holds while stalled
    cbm_ram #(
        .ADDR_W (RAM_ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (mem_req.re),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (ram_rdata)
    );

    // Merge RAM data into the result as it leaves the middle stage
    always_comb begin
        mid_item.result_kind = r_mid.kind;
        mid_item.rom_address = r_mid.rom_addr;
        mid_item.read_data   = r_mid.use_ram ? ram_rdata : r_mid.fixed_data;
    end

    always_comb begin
        n_mid_valid = r_mid_valid;
        if (in_accept) begin
            n_mid_valid = 1'b1;
        end else if (mid_move) begin
            n_mid_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (mid_move) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mid_valid <= n_mid_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mid <= issue;
        end
        if (mid_move) begin
            r_out <= mid_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transfer accepted with both stages full");

    a_ram_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_valid && r_mid.use_ram) |-> (r_mid.kind == KIND_READ))
        else $error("RAM data attached to a non-read result");

    a_rom_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind != KIND_ROM) |-> (o_out_item.rom_address == '0))
        else $error("ROM address set on a non-ROM result");

endmodule

@@ hdl/cbm_ram.sv @@
// ----------------------------------------------------------------------------
// cbm_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbm_ctrl
// Configuration and banking registers, bus decode and RAM request issue.
// ----------------------------------------------------------------------------
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_accept,
    input  t_in_item               i_item,
    output t_mem_req               o_mem,
    output t_issue                 o_issue
);

    logic [7:0]            r_rom_bank_count, n_rom_bank_count;
    logic [2:0]            r_ram_size_code,  n_ram_size_code;
    logic                  r_ram_enabled,    n_ram_enabled;
    logic [ROM_BANK_W-1:0] r_rom_bank,       n_rom_bank;
    logic [1:0]            r_ram_bank,       n_ram_bank;
    logic                  r_mode,           n_mode;

    logic [7:0]            mask;
    logic [15:0]           addr;
    logic                  is_write;
    logic                  rom_lo, rom_hi, ram_win;
    logic [ROM_BANK_W-1:0] wr_bank;
    logic [ROM_BANK_W-1:0] rd_bank;
    logic [RAM_BANK_W-1:0] ram_bank_idx;

    assign mask     = r_rom_bank_count - 8'd1;
    assign addr     = i_item.bus_address;
    assign is_write = i_item.opcode;
    assign rom_lo   = (addr[15:14] == 2'b00);
    assign rom_hi   = (addr[15:14] == 2'b01);
    assign ram_win  = (addr[15:13] == 3'b101);

    assign wr_bank = (i_item.write_data[ROM_BANK_W-1:0] == '0) ? ROM_BANK_W'(1)
                   : (i_item.write_data[ROM_BANK_W-1:0] & mask[ROM_BANK_W-1:0]);
    assign rd_bank = r_rom_bank & mask[ROM_BANK_W-1:0];

    // RAM bank select applies only above RAM_SIZE_MAX in banking mode, else bank 0
    assign ram_bank_idx = ((r_ram_size_code > RAM_SIZE_MAX) && r_mode)
                        ? r_ram_bank[RAM_BANK_W-1:0] : '0;

    always_comb begin
        n_rom_bank_count = r_rom_bank_count;
        n_ram_size_code  = r_ram_size_code;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROM_BANK_COUNT: n_rom_bank_count = i_cfg_data;
                CFG_RAM_SIZE_CODE:  n_ram_size_code  = i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ram_enabled = r_ram_enabled;
        n_rom_bank    = r_rom_bank;
        n_ram_bank    = r_ram_bank;
        n_mode        = r_mode;
        if (i_accept && is_write && !addr[15]) begin
            unique case (t_ctl_sel'(addr[14:13]))
                SEL_RAM_EN:   n_ram_enabled = (i_item.write_data[3:0] == RAM_EN_KEY);
                SEL_ROM_BANK: n_rom_bank    = wr_bank;
                SEL_RAM_BANK: n_ram_bank    = i_item.write_data[1:0];
                SEL_MODE:     n_mode        = i_item.write_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank_count <= 8'd2;
            r_ram_size_code  <= '0;
            r_ram_enabled    <= 1'b0;
            r_rom_bank       <= '0;
            r_ram_bank       <= '0;
            r_mode           <= 1'b0;
        end else begin
            r_rom_bank_count <= n_rom_bank_count;
            r_ram_size_code  <= n_ram_size_code;
            r_ram_enabled    <= n_ram_enabled;
            r_rom_bank       <= n_rom_bank;
            r_ram_bank       <= n_ram_bank;
            r_mode           <= n_mode;
        end
    end

    // RAM access goes out in the accept cycle
    always_comb begin
        o_mem.addr  = {ram_bank_idx, addr[RAM_OFF_W-1:0]};
        o_mem.wdata = i_item.write_data;
        o_mem.we    = i_accept && is_write && ram_win && r_ram_enabled;
        o_mem.re    = i_accept && !is_write && ram_win && r_ram_enabled;
    end

    always_comb begin
        o_issue.kind       = KIND_READ;
        o_issue.rom_addr   = '0;
        o_issue.use_ram    = 1'b0;
        o_issue.fixed_data = '0;
        if (is_write) begin
            o_issue.kind = KIND_WRITE;
        end else if (rom_lo) begin
            o_issue.kind     = KIND_ROM;
            o_issue.rom_addr = {{(ROM_ADDR_W-ROM_OFF_W){1'b0}}, addr[ROM_OFF_W-1:0]};
        end else if (rom_hi) begin
            o_issue.kind     = KIND_ROM;
            o_issue.rom_addr = {rd_bank, addr[ROM_OFF_W-1:0]};
        end else if (ram_win && r_ram_enabled) begin
            o_issue.use_ram = 1'b1;
        end else begin
            o_issue.fixed_data = BYTE_FF;
        end
    end

    a_we_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_ram_enabled && i_accept))
        else $error("RAM write issued while RAM disabled");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.we && o_mem.re))
        else $error("RAM read and write issued together");

endmodule

@@ tb/cartridge_bank_mapper_test.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_test
// Self-checking bench for the cartridge bank mapper. A queue-fed driver offers
// CPU bus transfers with random gaps, and a monitor takes results with random
// stalls. Every taken transfer is scored against a shadow of the banking
// registers and the cartridge RAM, and each result is compared field by field.
// The run steps through several bank-count and RAM-size settings.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_test;
    import cbm_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 64;
    localparam int HOLD_AT     = 100;
    localparam int RAM_WORDS   = RAM_BANKS * RAM_BANK_BYTES;

    // Register settings per phase: extremes, a zero bank count, a bank count
    // that is not a power of two, and RAM size codes on both sides of banking
    localparam logic [7:0] PHASE_BANKS [PHASES] =
        '{8'd128, 8'd32, 8'd4, 8'd0, 8'd12, 8'd64, 8'd16, 8'd2};
    localparam logic [2:0] PHASE_SIZES [PHASES] =
        '{3'd3, 3'd5, 3'd2, 3'd4, 3'd1, 3'd0, 3'd5, 3'd3};

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // CPU address map
    localparam logic [15:0] RAM_EN_TOP   = 16'h1FFF;
    localparam logic [15:0] ROM_BANK_TOP = 16'h3FFF;
    localparam logic [15:0] RAM_BANK_TOP = 16'h5FFF;
    localparam logic [15:0] ROM_TOP      = 16'h7FFF;
    localparam logic [15:0] XRAM_BASE    = 16'hA000;
    localparam logic [15:0] XRAM_TOP     = 16'hBFFF;

    // Banking state as seen by the CPU plus the two configuration registers
    typedef struct packed {
        logic [7:0]            bank_count;
        logic [2:0]            ram_size;
        logic                  ram_on;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  bank_mode;
    } t_bank_regs;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    // Transfers waiting to be offered, and results owed by the block
    t_in_item    pending_q[$];
    t_out_item   owed_q[$];

    // plan_regs tracks the state as the stimulus is built, live_regs as the
    // transfers are actually taken
    t_bank_regs  plan_regs;
    t_bank_regs  live_regs;
    logic [7:0]  ram_shadow  [RAM_WORDS];
    bit          ram_written [RAM_WORDS];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned results_seen   = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    bit          send_steady    = 1'b0;
    bit          recv_steady    = 1'b0;
    bit          long_hold_done = 1'b0;

    cartridge_bank_mapper dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial forever #6 clk = ~clk;

    function automatic t_bank_regs regs_after_reset();
        t_bank_regs r;
        r = '0;
        r.bank_count = 8'd2;
        return r;
    endfunction

    function automatic bit in_xram(logic [15:0] addr);
        return addr >= XRAM_BASE && addr <= XRAM_TOP;
    endfunction

    // Physical RAM byte behind a 0xA000-0xBFFF address; the bank select only
    // counts for large RAM in banking mode
    function automatic logic [RAM_ADDR_W-1:0] ram_slot(t_bank_regs r, logic [15:0] addr);
        logic [RAM_BANK_W-1:0] bank;
        bank = (r.ram_size > RAM_SIZE_MAX && r.bank_mode) ? r.ram_bank : '0;
        return {bank, addr[RAM_OFF_W-1:0]};
    endfunction

    // Result of one transfer, given the state before it and the RAM byte
    // it addresses
    function automatic t_out_item predict_access(t_bank_regs r, t_in_item it,
                                                 logic [7:0] stored);
        t_out_item  res;
        logic [7:0] mask;
        res  = '0;
        mask = r.bank_count - 8'd1;
        if (it.opcode == OP_WRITE) begin
            res.result_kind = KIND_WRITE;
        end else if (it.bus_address <= ROM_BANK_TOP) begin
            res.result_kind = KIND_ROM;
            res.rom_address = ROM_ADDR_W'(it.bus_address);
        end else if (it.bus_address <= ROM_TOP) begin
            res.result_kind = KIND_ROM;
            res.rom_address = {r.rom_bank & mask[ROM_BANK_W-1:0],
                               it.bus_address[ROM_OFF_W-1:0]};
        end else begin
            res.result_kind = KIND_READ;
            res.read_data   = (in_xram(it.bus_address) && r.ram_on) ? stored : BYTE_FF;
        end
        return res;
    endfunction

    // Banking register update caused by a write below 0x8000
    function automatic t_bank_regs apply_write(t_bank_regs r, t_in_item it);
        logic [7:0] mask;
        mask = r.bank_count - 8'd1;
        if (it.opcode == OP_WRITE) begin
            if (it.bus_address <= RAM_EN_TOP) begin
                r.ram_on = (it.write_data[3:0] == RAM_EN_KEY);
            end else if (it.bus_address <= ROM_BANK_TOP) begin
                // a written zero turns into bank one; other values go through the bank mask
                if (it.write_data[ROM_BANK_W-1:0] == '0)
                    r.rom_bank = ROM_BANK_W'(1);
                else
                    r.rom_bank = it.write_data[ROM_BANK_W-1:0] & mask[ROM_BANK_W-1:0];
            end else if (it.bus_address <= RAM_BANK_TOP) begin
                r.ram_bank = it.write_data[RAM_BANK_W-1:0];
            end else if (it.bus_address <= ROM_TOP) begin
                r.bank_mode = it.write_data[0];
            end
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (want === got) return 1'b1;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        return 1'b0;
    endfunction

    // Append one transfer to the stimulus. A RAM read of a byte never stored
    // since reset, with RAM enabled, is turned into a store to that byte.
    task automatic queue_access(input logic op, input logic [15:0] addr,
                                input logic [7:0] data);
        t_in_item              it;
        logic [RAM_ADDR_W-1:0] slot;
        it.opcode      = op;
        it.bus_address = addr;
        it.write_data  = data;
        if (in_xram(addr) && plan_regs.ram_on) begin
            slot = ram_slot(plan_regs, addr);
            if (!ram_written[slot]) it.opcode = OP_WRITE;
            if (it.opcode == OP_WRITE) ram_written[slot] = 1'b1;
        end
        plan_regs = apply_write(plan_regs, it);
        pending_q.push_back(it);
        queued_count++;
    endtask

    // Write one configuration register; only called while the block is idle
    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROM_BANK_COUNT: plan_regs.bank_count = value;
            CFG_RAM_SIZE_CODE:  plan_regs.ram_size   = value[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (accepted_count != queued_count || owed_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Bus driver: score each transfer at the edge that takes it, then offer the
    // next pending one after a random gap. Hold valid and payload while the
    // block stalls the input.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_bus
        logic [RAM_ADDR_W-1:0] slot;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            send_gap  = 0;
            live_regs = regs_after_reset();
        end else begin
            if (in_valid && in_ready) begin
                slot = ram_slot(live_regs, in_item.bus_address);
                owed_q.push_back(predict_access(live_regs, in_item, ram_shadow[slot]));
                if (in_item.opcode == OP_WRITE && in_xram(in_item.bus_address)
                        && live_regs.ram_on)
                    ram_shadow[slot] = in_item.write_data;
                live_regs = apply_write(live_regs, in_item);
                accepted_count++;
            end
            // Track register writes in the live copy of the state
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROM_BANK_COUNT: live_regs.bank_count = cfg_data;
                    CFG_RAM_SIZE_CODE:  live_regs.ram_size   = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_ready) begin
                // hold the offered transfer until it is taken
            end else if (send_gap != 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                in_item  <= pending_q.pop_front();
                in_valid <= 1'b1;
                send_gap = send_steady ? 0 : pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare every taken result with the oldest owed one and
    // stall the output at random. Once, after a hundred results, hold off for
    // a long stretch so the block fills up and drops its input ready.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch_results
        t_out_item want;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (owed_q.size() == 0) begin
                    $error("result with no transfer outstanding: 0x%0h", out_item);
                    fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    if (!field_ok("result_kind", 32'(want.result_kind),
                                  32'(out_item.result_kind)))
                        fail_count++;
                    if (!field_ok("rom_address", 32'(want.rom_address),
                                  32'(out_item.rom_address)))
                        fail_count++;
                    if (!field_ok("read_data", 32'(want.read_data),
                                  32'(out_item.read_data)))
                        fail_count++;
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AT) begin
                long_hold_done = 1'b1;
                recv_stall     = LONG_HOLD;
                out_ready      <= 1'b0;
            end else if (!recv_steady && $urandom_range(0, 3) == 0) begin
                recv_stall = pick_gap();
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Cycle limit: end a hung run
    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed pass at reset settings, then one random phase per
    // register setting. Drain between phases so register writes land while
    // the block is idle.
    // ------------------------------------------------------------------------
    initial begin : run
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        int unsigned pick;
        int unsigned goal;
        plan_regs = regs_after_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fixed ROM window edges, bank window with bank select still zero
        queue_access(OP_READ,  16'h0000, 8'h00);
        queue_access(OP_READ,  16'h3FFF, 8'hFF);
        queue_access(OP_READ,  16'h4000, 8'h00);
        // Zero selects bank one; large values wrap through the bank mask
        queue_access(OP_WRITE, 16'h2000, 8'h00);
        queue_access(OP_READ,  16'h7FFF, 8'h00);
        queue_access(OP_WRITE, 16'h3FFF, 8'hFE);
        queue_access(OP_READ,  16'h5A5A, 8'hFF);
        // Disabled RAM: read gives 0xFF, store is dropped
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'h77);
        // Enable, store at both ends, read back
        queue_access(OP_WRITE, 16'h0000, 8'h0A);
        queue_access(OP_WRITE, 16'hA000, 8'h00);
        queue_access(OP_WRITE, 16'hBFFF, 8'hFF);
        queue_access(OP_READ,  16'hA000, 8'h00);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        // RAM bank and mode select with small RAM: addressing stays unbanked
        queue_access(OP_WRITE, 16'h4000, 8'hFF);
        queue_access(OP_WRITE, 16'h6000, 8'h01);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        // Disable by a wrong key nibble
        queue_access(OP_WRITE, 16'h1FFF, 8'hA0);
        queue_access(OP_READ,  16'hBFFF, 8'h00);
        // Unmapped writes and reads, then a mode write and a RAM enable
        queue_access(OP_WRITE, 16'h8000, 8'h12);
        queue_access(OP_WRITE, 16'hFFFF, 8'h34);
        queue_access(OP_READ,  16'h9FFF, 8'h00);
        queue_access(OP_READ,  16'hC000, 8'hFF);
        queue_access(OP_WRITE, 16'h7FFF, 8'h00);
        queue_access(OP_WRITE, 16'h1000, 8'hFA);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_ROM_BANK_COUNT, PHASE_BANKS[ph]);
            write_reg(CFG_RAM_SIZE_CODE, 8'(PHASE_SIZES[ph]));
            @(negedge clk);
            // Phase 2 runs back to back on both sides, phase 5 on the output only
            send_steady = (ph == 2);
            recv_steady = (ph == 2 || ph == 5);
            goal = queued_count + PHASE_ITEMS;
            while (queued_count < goal) begin
                pick = $urandom_range(0, 99);
                op   = 1'($urandom);
                addr = 16'($urandom);
                data = 8'($urandom);
                if (pick < 6) begin
                    // toggle RAM enable, mostly on
                    op   = OP_WRITE;
                    addr = 16'($urandom_range(0, RAM_EN_TOP));
                    if ($urandom_range(0, 3) != 0) data[3:0] = RAM_EN_KEY;
                end else if (pick < 14) begin
                    // ROM bank, RAM bank or mode select
                    op   = OP_WRITE;
                    addr = 16'($urandom_range(RAM_EN_TOP + 1, ROM_TOP));
                end else if (pick < 60) begin
                    // RAM traffic, mostly on a hot set at both ends of the bank
                    addr[15:13] = XRAM_BASE[15:13];
                    if ($urandom_range(0, 3) != 0) addr[12:5] = addr[12] ? 8'hFF : 8'h00;
                end else if (pick < 85) begin
                    op       = OP_READ;
                    addr[15] = 1'b0;
                end
                queue_access(op, addr, data);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && owed_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cbm_pkg.sv
hdl/cbm_ram.sv
hdl/cbm_ctrl.sv
hdl/cartridge_bank_mapper.sv
tb/cartridge_bank_mapper_test.sv
